/* sv/gscn_pkg.sv */
// shared types and constants for the gamepad stick calibrate/normalize block
package gscn_pkg;

   localparam int unsigned AXIS_W   = 12;
   localparam int unsigned BTN_W    = 21;
   localparam int unsigned RAW_W    = 32;
   localparam int unsigned SUM_W    = 17;
   localparam int unsigned CNT_W    = 5;
   localparam int unsigned DZ_W     = 11;
   localparam int unsigned QUO_W    = 24;
   localparam int unsigned DVS_W    = 11;
   localparam int unsigned NUM_AXES = 4;
   localparam int unsigned PADDR_W  = 3;

   localparam logic [AXIS_W-1:0]  AXIS_FULL        = 12'd4095;
   localparam logic [PADDR_W-1:0] CSR_ADDR_DEADZONE = 3'd0;

   typedef struct packed {
      logic [RAW_W-1:0]  raw_buttons;
      logic [AXIS_W-1:0] raw_left_x;
      logic [AXIS_W-1:0] raw_left_y;
      logic [AXIS_W-1:0] raw_right_x;
      logic [AXIS_W-1:0] raw_right_y;
   } req_word_type;

   typedef struct packed {
      logic [BTN_W-1:0]  gamepad_buttons;
      logic [AXIS_W-1:0] out_left_x;
      logic [AXIS_W-1:0] out_left_y;
      logic [AXIS_W-1:0] out_right_x;
      logic [AXIS_W-1:0] out_right_y;
      logic              is_calibrated;
   } rsp_word_type;

   typedef struct packed {
      logic              start;
      logic [QUO_W-1:0]  dividend;
      logic [DVS_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [QUO_W-1:0]  quotient;
   } div_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CSTART,
      ST_CWAIT,
      ST_PREP,
      ST_NSTART,
      ST_NWAIT,
      ST_DONE
   } state_type;

   // raw bit index feeding each output button
   function automatic logic [BTN_W-1:0] remap_buttons(input logic [RAW_W-1:0] raw);
      logic [BTN_W-1:0] r;
      r = {raw[14], raw[25], raw[24], raw[13], raw[12], raw[18], raw[19], raw[16],
           raw[17], raw[10], raw[11], raw[9], raw[8], raw[7], raw[23], raw[6],
           raw[22], raw[1], raw[0], raw[3], raw[2]};
      return r;
   endfunction

endpackage

/* sv/gscn_div.sv */
// restoring divider, one quotient bit per cycle
module gscn_div (
   input  logic                     clock,
   input  logic                     reset,
   input  gscn_pkg::div_req_type    div_req,
   output gscn_pkg::div_rsp_type    div_rsp
);

   localparam int unsigned QW = gscn_pkg::QUO_W;
   localparam int unsigned VW = gscn_pkg::DVS_W;
   localparam int unsigned CW = $clog2(QW + 1);

   logic [QW-1:0] quo_ff, quo_in;
   logic [VW-1:0] rem_ff, rem_in;
   logic [VW-1:0] dvs_ff;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [VW:0]   trial;
   logic          fits;

   assign trial = {rem_ff, quo_ff[QW-1]};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         quo_in  = div_req.dividend;
         rem_in  = '0;
         cnt_in  = CW'(QW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? VW'(trial - {1'b0, dvs_ff}) : trial[VW-1:0];
         quo_in = {quo_ff[QW-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      if (div_req.start) dvs_ff <= div_req.divisor;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

/* sv/gamepad_stick_calibrate_normalize.sv */
// top level: stick centre calibration and axis normalization
// One word is taken at a time. A word seen before calibration completes goes straight to
// the output stage, and the input is free again in the same cycle that its result is valid. A
// calibrated word goes through prepare, start and the shared restoring divider, one quotient
// bit at a time, for each axis outside the deadzone. Each axis inside the deadzone takes
// only the prepare step. The word that completes calibration first computes the four
// centre means on the same divider.
// A new word is taken while the previous result still waits in the output register. The
// next result then waits until that one is taken.
module gamepad_stick_calibrate_normalize #(
   parameter int unsigned AXIS_CENTER       = 2048,
   parameter int unsigned PHYSICAL_RANGE    = 1600,
   parameter int unsigned CALIBRATION_COUNT = 20,
   parameter int unsigned CENTER_MAX_DELTA  = 256
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  gscn_pkg::req_word_type              req_word,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output gscn_pkg::rsp_word_type              rsp_word,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [gscn_pkg::PADDR_W-1:0]        paddr,
   input  logic [31:0]                         pwdata,
   output logic [31:0]                         prdata,
   output logic                                pready
);

   localparam int unsigned AW = gscn_pkg::AXIS_W;
   localparam int unsigned NA = gscn_pkg::NUM_AXES;
   localparam logic [AW-1:0]  CTR   = AW'(AXIS_CENTER);
   localparam logic [AW:0]    DELTA = (AW + 1)'(CENTER_MAX_DELTA);
   localparam logic [gscn_pkg::DZ_W-1:0]  PRNG = gscn_pkg::DZ_W'(PHYSICAL_RANGE);
   localparam logic [gscn_pkg::CNT_W-1:0] NCAL = gscn_pkg::CNT_W'(CALIBRATION_COUNT);
   localparam logic [AW-1:0]  TGT_HI = gscn_pkg::AXIS_FULL - CTR;

   gscn_pkg::state_type state_ff, state_in;

   logic [gscn_pkg::DZ_W-1:0]  dz_ff;
   logic                       cal_ff;
   logic [gscn_pkg::CNT_W-1:0] cnt_ff;
   logic [gscn_pkg::SUM_W-1:0] sum_ff [NA];
   logic [AW-1:0]              ctr_ff [NA];
   logic [AW-1:0]              ax_ff  [NA];
   logic [AW-1:0]              res_ff [NA];
   logic [gscn_pkg::BTN_W-1:0] btn_ff;
   logic [1:0]                 idx_ff;
   logic                       neg_ff;
   logic [AW-1:0]              tgt_ff;
   logic [gscn_pkg::DZ_W-1:0]  usable_ff;
   logic [gscn_pkg::QUO_W-1:0] prod_ff;
   logic                       rsp_valid_ff;
   gscn_pkg::rsp_word_type     rsp_word_ff;

   gscn_pkg::div_req_type      div_req;
   gscn_pkg::div_rsp_type      div_rsp;

   logic                       accept;
   logic [gscn_pkg::BTN_W-1:0] btn_now;
   logic [AW-1:0]              ax_now [NA];
   logic                       ok;
   logic [gscn_pkg::CNT_W-1:0] cnt_next;
   logic                       cal_now;
   logic [gscn_pkg::DZ_W-1:0]  dz_eff;
   logic                       neg;
   logic [AW-1:0]              mag;
   logic                       in_dz;
   logic [gscn_pkg::QUO_W-1:0] scaled;
   logic                       out_free;

   gscn_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign pready = 1'b1;
   assign prdata = (paddr == gscn_pkg::CSR_ADDR_DEADZONE) ? {21'd0, dz_ff} : '0;

   assign accept    = req_valid && !req_stall;
   assign req_stall = state_ff != gscn_pkg::ST_IDLE;
   assign btn_now   = gscn_pkg::remap_buttons(req_word.raw_buttons);
   assign ax_now[0] = req_word.raw_left_x;
   assign ax_now[1] = req_word.raw_left_y;
   assign ax_now[2] = req_word.raw_right_x;
   assign ax_now[3] = req_word.raw_right_y;

   always_comb begin
      ok = btn_now == '0;
      for (int i = 0; i < NA; i++) begin
         if (((ax_now[i] >= CTR) ? {1'b0, ax_now[i] - CTR} : {1'b0, CTR - ax_now[i]})
             > DELTA) ok = 1'b0;
      end
   end

   assign cnt_next = cnt_ff + 1'b1;
   assign cal_now  = cal_ff || (ok && cnt_next >= NCAL && cnt_next != '0);

   // normalization of the axis under idx_ff
   assign dz_eff = (dz_ff >= PRNG) ? PRNG - 1'b1 : dz_ff;
   assign neg    = ax_ff[idx_ff] < ctr_ff[idx_ff];
   assign mag    = neg ? ctr_ff[idx_ff] - ax_ff[idx_ff] : ax_ff[idx_ff] - ctr_ff[idx_ff];
   assign in_dz  = mag <= AW'(dz_eff);
   assign scaled = (div_rsp.quotient > gscn_pkg::QUO_W'(tgt_ff))
                   ? gscn_pkg::QUO_W'(tgt_ff) : div_rsp.quotient;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      div_req.start    = 1'b0;
      div_req.dividend = prod_ff + gscn_pkg::QUO_W'(usable_ff >> 1);
      div_req.divisor  = usable_ff;
      unique case (state_ff)
         gscn_pkg::ST_IDLE: begin
            if (accept) begin
               if (cal_ff) state_in = gscn_pkg::ST_PREP;
               else if (cal_now) state_in = gscn_pkg::ST_CSTART;
               else state_in = gscn_pkg::ST_DONE;
            end
         end
         gscn_pkg::ST_CSTART: begin
            div_req.start    = 1'b1;
            div_req.dividend = gscn_pkg::QUO_W'(sum_ff[idx_ff]);
            div_req.divisor  = gscn_pkg::DVS_W'(cnt_ff);
            state_in = gscn_pkg::ST_CWAIT;
         end
         gscn_pkg::ST_CWAIT: begin
            if (div_rsp.done)
               state_in = (idx_ff == 2'd3) ? gscn_pkg::ST_PREP : gscn_pkg::ST_CSTART;
         end
         gscn_pkg::ST_PREP: begin
            if (in_dz) state_in = (idx_ff == 2'd3) ? gscn_pkg::ST_DONE : gscn_pkg::ST_PREP;
            else state_in = gscn_pkg::ST_NSTART;
         end
         gscn_pkg::ST_NSTART: begin
            div_req.start = 1'b1;
            state_in = gscn_pkg::ST_NWAIT;
         end
         gscn_pkg::ST_NWAIT: begin
            if (div_rsp.done)
               state_in = (idx_ff == 2'd3) ? gscn_pkg::ST_DONE : gscn_pkg::ST_PREP;
         end
         gscn_pkg::ST_DONE: begin
            if (out_free) state_in = gscn_pkg::ST_IDLE;
         end
         default: state_in = gscn_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gscn_pkg::ST_IDLE;
         dz_ff        <= '0;
         cal_ff       <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
         for (int i = 0; i < NA; i++) begin
            sum_ff[i] <= '0;
            ctr_ff[i] <= CTR;
         end
      end else begin
         state_ff <= state_in;
         if (psel && penable && pwrite && pready && paddr == gscn_pkg::CSR_ADDR_DEADZONE)
            dz_ff <= pwdata[gscn_pkg::DZ_W-1:0];
         if (state_ff == gscn_pkg::ST_DONE && out_free) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            gscn_pkg::ST_IDLE: begin
               idx_ff <= '0;
               if (accept && !cal_ff) begin
                  if (ok) begin
                     cnt_ff <= cnt_next;
                     for (int i = 0; i < NA; i++)
                        sum_ff[i] <= sum_ff[i] + gscn_pkg::SUM_W'(ax_now[i]);
                  end else begin
                     cnt_ff <= '0;
                     for (int i = 0; i < NA; i++) sum_ff[i] <= '0;
                  end
                  cal_ff <= cal_now;
               end
            end
            gscn_pkg::ST_CWAIT: begin
               if (div_rsp.done) begin
                  ctr_ff[idx_ff] <= div_rsp.quotient[AW-1:0];
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            gscn_pkg::ST_PREP: begin
               if (in_dz) idx_ff <= idx_ff + 1'b1;
            end
            gscn_pkg::ST_NWAIT: begin
               if (div_rsp.done) idx_ff <= idx_ff + 1'b1;
            end
            default: ;
         endcase
      end
      // payload
      if (state_ff == gscn_pkg::ST_IDLE && accept) begin
         btn_ff <= btn_now;
         for (int i = 0; i < NA; i++) begin
            ax_ff[i]  <= ax_now[i];
            res_ff[i] <= CTR;
         end
      end
      if (state_ff == gscn_pkg::ST_PREP) begin
         neg_ff    <= neg;
         tgt_ff    <= neg ? CTR : TGT_HI;
         usable_ff <= PRNG - dz_eff;
         prod_ff   <= gscn_pkg::QUO_W'(mag - AW'(dz_eff)) *
                      gscn_pkg::QUO_W'(neg ? CTR : TGT_HI);
         if (in_dz) res_ff[idx_ff] <= CTR;
      end
      if (state_ff == gscn_pkg::ST_NWAIT && div_rsp.done)
         res_ff[idx_ff] <= neg_ff ? CTR - scaled[AW-1:0] : CTR + scaled[AW-1:0];
      if (state_ff == gscn_pkg::ST_DONE && out_free) begin
         rsp_word_ff.gamepad_buttons <= btn_ff;
         rsp_word_ff.out_left_x      <= res_ff[0];
         rsp_word_ff.out_left_y      <= gscn_pkg::AXIS_FULL - res_ff[1];
         rsp_word_ff.out_right_x     <= res_ff[2];
         rsp_word_ff.out_right_y     <= gscn_pkg::AXIS_FULL - res_ff[3];
         rsp_word_ff.is_calibrated   <= cal_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

/* sv/gscn_checker.sv */
// port-level checks for the gamepad stick block, bound to the top level
module gscn_checker #(
   parameter int unsigned AXIS_CENTER = 2048
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input gscn_pkg::rsp_word_type rsp_word
);

   localparam logic [gscn_pkg::AXIS_W-1:0] CTR = gscn_pkg::AXIS_W'(AXIS_CENTER);

   logic seen_cal_ff;

   always_ff @(posedge clock) begin
      if (reset) seen_cal_ff <= 1'b0;
      else if (rsp_valid && !rsp_stall && rsp_word.is_calibrated) seen_cal_ff <= 1'b1;
   end

   a_rst_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word valid right after reset");

   a_one_word: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input not held off after taking a word");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("stalled result word changed");

   a_cal_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && seen_cal_ff |-> rsp_word.is_calibrated)
      else $error("calibration lost");

   a_uncal_centre: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_word.is_calibrated |->
         rsp_word.out_left_x == CTR && rsp_word.out_right_x == CTR &&
         rsp_word.out_left_y == gscn_pkg::AXIS_FULL - CTR)
      else $error("uncalibrated word not at centre");

endmodule

bind gamepad_stick_calibrate_normalize gscn_checker #(.AXIS_CENTER(AXIS_CENTER)) u_chk (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_word  (rsp_word)
);

/* sim/tb.sv */
// testbench for the gamepad stick calibrate/normalize block
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int AX_CENTER   = 2048;
   localparam int PHYS_RANGE  = 1600;
   localparam int CAL_COUNT   = 20;
   localparam int MAX_DELTA   = 256;
   localparam int WATCHDOG    = 20000;
   localparam int N_RANDOM    = 1500;

   typedef enum int {
      ROW_PLAIN,
      ROW_CHECK
   } row_kind_type;

   typedef struct {
      row_kind_type kind;
      gscn_pkg::req_word_type rq;
      gscn_pkg::rsp_word_type rs;
   } stim_row_type;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   gscn_pkg::req_word_type req_word;
   logic rsp_valid;
   logic rsp_stall;
   gscn_pkg::rsp_word_type rsp_word;
   logic psel;
   logic penable;
   logic pwrite;
   logic [gscn_pkg::PADDR_W-1:0] paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic pready;

   gamepad_stick_calibrate_normalize u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_word(rsp_word),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // predictor state
   int unsigned dz_reg;
   bit cal_done;
   int unsigned good_count;
   int unsigned sums[4];
   int unsigned centres[4];

   gscn_pkg::rsp_word_type pending_rsp[$];
   int errors;
   int idle_cycles;
   bit rx_hold;
   bit rx_idle_on;
   bit tx_idle_on;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic logic [gscn_pkg::BTN_W-1:0] map_raw_buttons(logic [31:0] raw);
      int src[21] = '{2, 3, 0, 1, 22, 6, 23, 7, 8, 9, 11, 10, 17, 16, 19, 18,
                      12, 13, 24, 25, 14};
      logic [gscn_pkg::BTN_W-1:0] b;
      b = '0;
      for (int i = 0; i < 21; i++) b[i] = raw[src[i]];
      return b;
   endfunction

   function automatic int unsigned scale_axis(int unsigned v, int unsigned c);
      int unsigned dz, mag, usable, target, scaled;
      bit neg;
      dz = (dz_reg >= PHYS_RANGE) ? PHYS_RANGE - 1 : dz_reg;
      neg = v < c;
      mag = neg ? c - v : v - c;
      if (mag <= dz) return AX_CENTER;
      usable = PHYS_RANGE - dz;
      target = neg ? AX_CENTER : 4095 - AX_CENTER;
      scaled = ((mag - dz) * target + usable / 2) / usable;
      if (scaled > target) scaled = target;
      return (neg ? AX_CENTER - scaled : AX_CENTER + scaled) & 12'hfff;
   endfunction

   function automatic gscn_pkg::rsp_word_type calibrate_and_normalize(
      gscn_pkg::req_word_type rq);
      gscn_pkg::rsp_word_type rs;
      int unsigned ax[4];
      int unsigned res[4];
      bit ok;
      logic [gscn_pkg::BTN_W-1:0] btn;
      btn = map_raw_buttons(rq.raw_buttons);
      ax = '{rq.raw_left_x, rq.raw_left_y, rq.raw_right_x, rq.raw_right_y};
      if (!cal_done) begin
         ok = (btn == '0);
         for (int i = 0; i < 4; i++)
            if ((ax[i] > AX_CENTER ? ax[i] - AX_CENTER : AX_CENTER - ax[i]) > MAX_DELTA)
               ok = 0;
         if (!ok) begin
            good_count = 0;
            sums = '{0, 0, 0, 0};
         end else begin
            for (int i = 0; i < 4; i++) sums[i] = (sums[i] + ax[i]) & 17'h1ffff;
            good_count = (good_count + 1) & 5'h1f;
            if (good_count >= CAL_COUNT) begin
               for (int i = 0; i < 4; i++)
                  centres[i] = (sums[i] / good_count) & 12'hfff;
               cal_done = 1;
            end
         end
      end
      for (int i = 0; i < 4; i++)
         res[i] = cal_done ? scale_axis(ax[i], centres[i]) : AX_CENTER;
      rs.gamepad_buttons = btn;
      rs.out_left_x = 12'(res[0]);
      rs.out_left_y = 12'(4095 - res[1]);
      rs.out_right_x = 12'(res[2]);
      rs.out_right_y = 12'(4095 - res[3]);
      rs.is_calibrated = cal_done;
      return rs;
   endfunction

   task automatic csr_write(int unsigned value);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= gscn_pkg::CSR_ADDR_DEADZONE;
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      dz_reg = value & 11'h7ff;
      @(posedge clock);
      if (!pready || prdata !== (value & 32'h7ff)) begin
         $display("%0t: deadzone exp %0d got %0d", $time, value & 32'h7ff, prdata);
         errors++;
      end
   endtask

   // offer one word and hold it until accepted
   task automatic send_word(gscn_pkg::req_word_type rq);
      int gap;
      if (tx_idle_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 13);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word <= rq;
      do @(posedge clock); while (req_stall);
      pending_rsp.push_back(calibrate_and_normalize(rq));
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (250) @(posedge clock);
   endtask

   function automatic gscn_pkg::req_word_type centred_word(int spread);
      gscn_pkg::req_word_type rq;
      rq.raw_buttons = $urandom() & 32'hfc30_8030; // unmapped bits only
      rq.raw_left_x = 12'(AX_CENTER - spread + $urandom_range(0, 2 * spread));
      rq.raw_left_y = 12'(AX_CENTER - spread + $urandom_range(0, 2 * spread));
      rq.raw_right_x = 12'(AX_CENTER - spread + $urandom_range(0, 2 * spread));
      rq.raw_right_y = 12'(AX_CENTER - spread + $urandom_range(0, 2 * spread));
      return rq;
   endfunction

   function automatic gscn_pkg::req_word_type any_word();
      gscn_pkg::req_word_type rq;
      rq.raw_buttons = $urandom();
      rq.raw_left_x = 12'($urandom_range(0, 4095));
      rq.raw_left_y = 12'($urandom_range(0, 4095));
      rq.raw_right_x = 12'($urandom_range(0, 4095));
      rq.raw_right_y = 12'($urandom_range(0, 4095));
      return rq;
   endfunction

   // result checker
   always @(posedge clock) begin
      gscn_pkg::rsp_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected word %h", $time, rsp_word);
            errors++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_word.gamepad_buttons !== want.gamepad_buttons) begin
               $display("%0t: buttons exp %h got %h", $time,
                        want.gamepad_buttons, rsp_word.gamepad_buttons);
               errors++;
            end
            if (rsp_word.out_left_x !== want.out_left_x) begin
               $display("%0t: left_x exp %0d got %0d", $time,
                        want.out_left_x, rsp_word.out_left_x);
               errors++;
            end
            if (rsp_word.out_left_y !== want.out_left_y) begin
               $display("%0t: left_y exp %0d got %0d", $time,
                        want.out_left_y, rsp_word.out_left_y);
               errors++;
            end
            if (rsp_word.out_right_x !== want.out_right_x) begin
               $display("%0t: right_x exp %0d got %0d", $time,
                        want.out_right_x, rsp_word.out_right_x);
               errors++;
            end
            if (rsp_word.out_right_y !== want.out_right_y) begin
               $display("%0t: right_y exp %0d got %0d", $time,
                        want.out_right_y, rsp_word.out_right_y);
               errors++;
            end
            if (rsp_word.is_calibrated !== want.is_calibrated) begin
               $display("%0t: calibrated exp %0d got %0d", $time,
                        want.is_calibrated, rsp_word.is_calibrated);
               errors++;
            end
         end
      end
   end

   // receiver stall pattern
   initial begin
      int n;
      rsp_stall = 1'b0;
      @(negedge reset);
      forever begin
         if (rx_hold) begin
            rsp_stall <= 1'b1;
            repeat (800) @(posedge clock);
            rx_hold = 0;
            rsp_stall <= 1'b0;
            @(posedge clock);
         end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
            n = $urandom_range(1, 13);
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
            rsp_stall <= 1'b0;
            @(posedge clock);
         end else begin
            @(posedge clock);
         end
      end
   end

   // watchdog on handshakes
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else if (idle_cycles >= WATCHDOG) begin
         $display("gamepad_stick_calibrate_normalize: mismatch");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      stim_row_type rows[$];
      stim_row_type r;
      gscn_pkg::req_word_type rq;
      gscn_pkg::rsp_word_type rs;
      int dz_list[6];
      int unsigned saved_count;
      int unsigned saved_sums[4];

      dz_list = '{0, 1599, 2047, 100, 800, 1};
      reset = 1'b1;
      req_valid = 1'b0;
      req_word = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      errors = 0;
      idle_cycles = 0;
      rx_hold = 0;
      rx_idle_on = 1;
      tx_idle_on = 1;
      dz_reg = 0;
      cal_done = 0;
      good_count = 0;
      sums = '{0, 0, 0, 0};
      centres = '{AX_CENTER, AX_CENTER, AX_CENTER, AX_CENTER};
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rows before calibration: output is fixed centre
      rs = '{gamepad_buttons: 21'h1fffff, out_left_x: 12'd2048, out_left_y: 12'd2047,
             out_right_x: 12'd2048, out_right_y: 12'd2047, is_calibrated: 1'b0};
      rows.push_back('{ROW_CHECK, '{32'hffffffff, 12'd0, 12'd4095, 12'd0, 12'd4095}, rs});
      rs.gamepad_buttons = '0;
      rows.push_back('{ROW_CHECK, '{32'h0, 12'd4095, 12'd0, 12'd4095, 12'd0}, rs});
      rows.push_back('{ROW_CHECK, '{32'hfc30_8030, 12'd2048, 12'd2048, 12'd2048,
                       12'd2048}, rs});
      // delta edges: 256 away qualifies, 257 breaks the run
      rows.push_back('{ROW_PLAIN, '{32'h0, 12'd1792, 12'd2304, 12'd2048, 12'd2048}, rs});
      rows.push_back('{ROW_PLAIN, '{32'h0, 12'd1791, 12'd2048, 12'd2048, 12'd2305}, rs});
      rows.push_back('{ROW_PLAIN, '{32'h4, 12'd2048, 12'd2048, 12'd2048, 12'd2048}, rs});
      // a run of qualifying words with unmapped bits set completes calibration
      for (int i = 0; i < CAL_COUNT; i++)
         rows.push_back('{ROW_PLAIN, '{32'hfc30_8030, 12'(2040 + i), 12'd2100,
                          12'd1990, 12'(2048 - i)}, rs});
      foreach (rows[i]) begin
         r = rows[i];
         if (r.kind == ROW_CHECK) begin
            saved_count = good_count;
            saved_sums = sums;
            rs = calibrate_and_normalize(r.rq);
            if (rs !== r.rs) begin
               $display("%0t: table row %0d exp %h got %h", $time, i, r.rs, rs);
               errors++;
            end
            // undo the predictor step, send_word repeats it
            good_count = saved_count;
            sums = saved_sums;
         end
         send_word(r.rq);
      end
      drain_results();

      // calibrated: extremes, a near-centre word and a random word at each deadzone, including the saturated ones
      foreach (dz_list[d]) begin
         csr_write(dz_list[d]);
         send_word('{32'h0, 12'd0, 12'd4095, 12'd4095, 12'd0});
         send_word('{32'h03ff_ffcf, 12'd2039, 12'd2100, 12'd1990, 12'd2038});
         send_word(any_word());
         drain_results();
      end

      // long receiver hold while the sender keeps offering
      rx_hold = 1;
      for (int i = 0; i < 6; i++) send_word(any_word());
      drain_results();

      // random phases: fresh calibration needs a reset, so stay calibrated and vary
      // the deadzone and stimulus mix
      for (int ph = 0; ph < 6; ph++) begin
         csr_write(ph == 0 ? 0 : (ph == 5 ? 1599 : $urandom_range(0, 2047)));
         if (ph == 5) begin
            rx_idle_on = 0;
            tx_idle_on = 0;
         end
         for (int i = 0; i < N_RANDOM / 6; i++) begin
            case ($urandom_range(0, 3))
               0: rq = centred_word($urandom_range(1, 300));
               1: rq = centred_word(1700);
               default: rq = any_word();
            endcase
            send_word(rq);
         end
         drain_results();
      end

      if (errors == 0)
         $display("gamepad_stick_calibrate_normalize: match");
      else
         $display("gamepad_stick_calibrate_normalize: mismatch");
      $finish;
   end

endmodule

/* gamepad_stick_calibrate_normalize.f */
sv/gscn_pkg.sv
sv/gscn_div.sv
sv/gamepad_stick_calibrate_normalize.sv
sv/gscn_checker.sv
sim/tb.sv
